[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 2;

  typedef struct packed {
    logic add_en;
    logic remove_en;
  } ctrl_t;

endpackage

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a tag and a priority, and on each
// operation keeps its entry, takes the new entry, or takes a neighbor's.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned TAG_WIDTH      = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic                      clk,
  input  spq_pkg::ctrl_t            ctrl,
  input  logic                      occupied,
  input  logic [TAG_WIDTH-1:0]      new_tag,
  input  logic [PRIORITY_WIDTH-1:0] new_pri,
  input  logic                      prev_stay,
  input  logic [TAG_WIDTH-1:0]      prev_tag,
  input  logic [PRIORITY_WIDTH-1:0] prev_pri,
  input  logic [TAG_WIDTH-1:0]      next_tag,
  input  logic [PRIORITY_WIDTH-1:0] next_pri,
  output logic                      stay,
  output logic [TAG_WIDTH-1:0]      tag,
  output logic [PRIORITY_WIDTH-1:0] pri,
  output logic [TAG_WIDTH-1:0]      tag_next,
  output logic [PRIORITY_WIDTH-1:0] pri_next
);

  assign stay = occupied && ($signed(pri) >= $signed(new_pri));

  always_comb begin
    tag_next = tag;
    pri_next = pri;
    if (ctrl.add_en) begin
      if (stay) begin
        tag_next = tag;
        pri_next = pri;
      end else if (prev_stay) begin
        tag_next = new_tag;
        pri_next = new_pri;
      end else begin
        tag_next = prev_tag;
        pri_next = prev_pri;
      end
    end else if (ctrl.remove_en) begin
      tag_next = next_tag;
      pri_next = next_pri;
    end
  end

  always_ff @(posedge clk) begin
    tag <= tag_next;
    pri <= pri_next;
  end

endmodule

[sv/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept sorted in a chain of cells; equal priorities
// leave in arrival order.
//
//  channel  dir  fields (tdata, low bit up)
//  s_*      in   kind, item_tag, priority_req
//  m_*      out  removed_tag, head_tag, head_priority, queue_empty,
//                occupancy, error_code
//
// One item per cycle while the result register drains: every cell compares
// against the new priority and shifts in the same cycle; the result is registered.
// s_tready is high while the result register is empty or being drained.
// Reset clears the entry count and the result valid; slots need no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int unsigned DEPTH          = 16,
  parameter int unsigned TAG_WIDTH      = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // kind, item_tag, priority_req
  input  logic [((spq_pkg::KIND_W + TAG_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // removed_tag, head_tag, head_priority, queue_empty, occupancy, error_code
  output logic [((2 * TAG_WIDTH + PRIORITY_WIDTH + 1 + $clog2(DEPTH + 1)
                  + spq_pkg::ERR_W + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned OUT_BITS = 2 * TAG_WIDTH + PRIORITY_WIDTH + 1 + CW + spq_pkg::ERR_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned TAG_LO   = spq_pkg::KIND_W;
  localparam int unsigned PRI_LO   = spq_pkg::KIND_W + TAG_WIDTH;

  spq_pkg::kind_t            kind;
  logic [TAG_WIDTH-1:0]      new_tag;
  logic [PRIORITY_WIDTH-1:0] new_pri;
  logic                      accept;
  spq_pkg::ctrl_t            ctrl;
  spq_pkg::err_t             err;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;

  logic                      stay     [DEPTH];
  logic [TAG_WIDTH-1:0]      tag_q    [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pri_q    [DEPTH];
  logic [TAG_WIDTH-1:0]      tag_d    [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pri_d    [DEPTH];

  logic [TAG_WIDTH-1:0]      removed_tag;
  logic [TAG_WIDTH-1:0]      head_tag;
  logic [PRIORITY_WIDTH-1:0] head_priority;
  logic                      queue_empty;
  logic [OUT_BITS-1:0]       out_bits;
  logic [OUT_W-1:0]          out_data;

  assign kind     = spq_pkg::kind_t'(s_tdata[spq_pkg::KIND_W-1:0]);
  assign new_tag  = s_tdata[TAG_LO +: TAG_WIDTH];
  assign new_pri  = s_tdata[PRI_LO +: PRIORITY_WIDTH];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    ctrl        = '0;
    err         = spq_pkg::ERR_OK;
    count_next  = count;
    removed_tag = '0;
    if (accept) begin
      case (kind)
        spq_pkg::KIND_ADD: begin
          if (count == CW'(DEPTH)) begin
            err = spq_pkg::ERR_FULL;
          end else begin
            ctrl.add_en = 1'b1;
            count_next  = count + CW'(1);
          end
        end
        spq_pkg::KIND_REMOVE: begin
          if (count == '0) begin
            err = spq_pkg::ERR_EMPTY;
          end else begin
            ctrl.remove_en = 1'b1;
            count_next     = count - CW'(1);
            removed_tag    = tag_q[0];
          end
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_stay;
    logic [TAG_WIDTH-1:0]      prev_tag;
    logic [PRIORITY_WIDTH-1:0] prev_pri;
    logic [TAG_WIDTH-1:0]      next_tag;
    logic [PRIORITY_WIDTH-1:0] next_pri;

    if (i == 0) begin : g_first
      assign prev_stay = 1'b1;
      assign prev_tag  = new_tag;
      assign prev_pri  = new_pri;
    end else begin : g_inner
      assign prev_stay = stay[i-1];
      assign prev_tag  = tag_q[i-1];
      assign prev_pri  = pri_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_tag = tag_q[i];
      assign next_pri = pri_q[i];
    end else begin : g_body
      assign next_tag = tag_q[i+1];
      assign next_pri = pri_q[i+1];
    end

    spq_cell #(
      .TAG_WIDTH      (TAG_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count > CW'(i)),
      .new_tag   (new_tag),
      .new_pri   (new_pri),
      .prev_stay (prev_stay),
      .prev_tag  (prev_tag),
      .prev_pri  (prev_pri),
      .next_tag  (next_tag),
      .next_pri  (next_pri),
      .stay      (stay[i]),
      .tag       (tag_q[i]),
      .pri       (pri_q[i]),
      .tag_next  (tag_d[i]),
      .pri_next  (pri_d[i])
    );
  end

  assign queue_empty   = (count_next == '0);
  assign head_tag      = queue_empty ? '0 : tag_d[0];
  assign head_priority = queue_empty ? '0 : pri_d[0];
  assign out_bits      = {err, count_next, queue_empty, head_priority, head_tag, removed_tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= OUT_W'(out_bits);
    end
  end

  assign m_tdata = out_data;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    accept && kind == spq_pkg::KIND_REMOVE && count != '0 |=>
      count == $past(count) - CW'(1))
    else $error("remove did not shrink the queue");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> $signed(pri_q[0]) >= $signed(pri_q[1]))
    else $error("head outranked by second slot");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    accept && err == spq_pkg::ERR_FULL |-> count == CW'(DEPTH))
    else $error("full error with free slots");

endmodule
